// ----- rtl/core/sef_pkg.sv -----
`timescale 1ns / 1ps
package sef_pkg;

	localparam int RING_DEPTH = 65536;
	localparam int MAX_TAPS   = 64;

	localparam int RING_AW   = $clog2(RING_DEPTH);
	localparam int TAP_AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int CNT_W     = TAP_AW + 1;
	localparam int SAMPLE_W  = 24;
	localparam int COEF_W    = 24;
	localparam int DELAY_W   = 16;
	localparam int IDX_W     = 6;
	localparam int CFG_W     = 7;
	localparam int PROD_W    = SAMPLE_W + COEF_W;
	localparam int ACC_W     = PROD_W + TAP_AW + 2;
	localparam int FRAC_DROP = 20;
	localparam int RING_W    = 2 * SAMPLE_W;
	localparam int TAP_W     = DELAY_W + COEF_W;

	localparam int SAMPLE_MAX = 8388607;
	localparam int SAMPLE_MIN = -8388608;

	localparam logic [1:0] KIND_SAMPLE  = 2'd0;
	localparam logic [1:0] KIND_LOAD_FF = 2'd1;
	localparam logic [1:0] KIND_LOAD_FB = 2'd2;

	localparam logic REG_FF_COUNT = 1'b0;
	localparam logic REG_FB_COUNT = 1'b1;

	typedef struct packed {
		logic [1:0]                 kind;
		logic signed [SAMPLE_W-1:0] sample_in;
		logic [IDX_W-1:0]           tap_index;
		logic [DELAY_W-1:0]         tap_delay;
		logic signed [COEF_W-1:0]   tap_coef;
	} item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] filtered_out;
		logic                       saturated;
	} result_t;

	// one tap operation leaving the ring read stage
	typedef struct packed {
		logic                     valid;
		logic                     fb;
		logic signed [COEF_W-1:0] coef;
		logic [RING_AW-1:0]       addr;
	} mac_op_t;

endpackage

// ----- rtl/core/sef_mac.sv -----
`timescale 1ns / 1ps
module sef_mac (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  clear,
	input  sef_pkg::mac_op_t                      op,
	input  logic [sef_pkg::RING_W-1:0]            ring_word,
	input  logic [sef_pkg::RING_AW-1:0]           wpos,
	input  logic signed [sef_pkg::SAMPLE_W-1:0]   sample,
	input  logic                                  wrapped,
	output logic                                  busy,
	output logic signed [sef_pkg::ACC_W-1:0]      acc
);
	import sef_pkg::*;

	logic                       written;
	logic                       hit_cur;
	logic signed [SAMPLE_W-1:0] in_half;
	logic signed [SAMPLE_W-1:0] out_half;
	logic signed [SAMPLE_W-1:0] operand;
	logic signed [PROD_W-1:0]   prod_s3;
	logic                       v_s3;
	logic signed [ACC_W-1:0]    acc_q;

	assign in_half  = ring_word[RING_W-1:SAMPLE_W];
	assign out_half = ring_word[SAMPLE_W-1:0];

	// slots not yet written since reset read as zero (fill count = wpos until wrap)
	assign written = wrapped || (op.addr < wpos);
	assign hit_cur = (op.addr == wpos);

	always_comb begin
		if (op.fb) begin
			operand = written ? out_half : '0;
		end else if (hit_cur) begin
			operand = sample;
		end else begin
			operand = written ? in_half : '0;
		end
	end

	always_ff @(posedge clk) begin
		prod_s3 <= operand * op.coef;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3  <= 1'b0;
			acc_q <= '0;
		end else begin
			v_s3 <= op.valid;
			if (clear) begin
				acc_q <= '0;
			end else if (v_s3) begin
				acc_q <= acc_q + ACC_W'(prod_s3);
			end
		end
	end

	assign busy = v_s3;
	assign acc  = acc_q;

endmodule

// ----- rtl/core/sparse_echo_filter.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// item      in         item_valid / item_stall   sef_pkg::item_t (sample or tap load)
// result    out        result_valid / result_stall  sef_pkg::result_t (one per sample)
// apb       in         psel/penable/pwrite/pready  tap counts, 4-byte stride
//
// A sample beat holds off new items until its write-back: one tap per cycle
// through the tap table read, the ring read and the multiplier, then drain,
// round and write, which loads the result register. Load beats and unused
// kinds are taken without leaving idle and give no result.
// Both rings share one 48-bit memory {input, output}; unwritten slots read as
// zero by a fill count, so reset needs no clearing pass.
// A stalled result holds in the output register; the next beat is already
// accepted, and its write-back waits only if the register is still full.
module sparse_echo_filter (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  sef_pkg::item_t        item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output sef_pkg::result_t      result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import sef_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RUN   = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_ROUND = 3'd3;
	localparam logic [2:0] ST_WRITE = 3'd4;

	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (FRAC_DROP - 1));
	localparam logic signed [ACC_W-1:0] R_MAX      = ACC_W'(SAMPLE_MAX);
	localparam logic signed [ACC_W-1:0] R_MIN      = ACC_W'(SAMPLE_MIN);

	logic [2:0]              state_q;
	logic [CFG_W-1:0]        ff_cnt_q;
	logic [CFG_W-1:0]        fb_cnt_q;
	logic [RING_AW-1:0]      wp_q;
	logic                    wrapped_q;
	logic [CNT_W-1:0]        idx_q;
	logic                    fb_q;
	logic signed [SAMPLE_W-1:0] sample_q;

	// memories
	logic [TAP_W-1:0]        tap_mem [2**(TAP_AW+1)];
	logic [RING_W-1:0]       ring_mem [RING_DEPTH];

	logic                    accept;
	logic                    cfg_we;
	logic                    tap_we;
	logic [TAP_AW:0]         tap_waddr;
	logic [TAP_AW:0]         tap_raddr;
	logic [CNT_W-1:0]        nff;
	logic [CNT_W-1:0]        nfb;
	logic [CNT_W-1:0]        lim;
	logic                    issue;

	logic                    v_s1;
	logic                    fb_s1;
	logic [TAP_W-1:0]        tap_rd_s1;
	logic [RING_AW-1:0]      ring_raddr;
	logic [DELAY_W-1:0]      delay_s1;

	logic [RING_W-1:0]       ring_rd_s2;
	mac_op_t                 op_s2;

	logic                    mac_busy;
	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W-1:0] acc_rnd;
	logic signed [ACC_W-1:0] acc_sh;
	logic signed [SAMPLE_W-1:0] r_q;
	logic                    sat_q;
	logic                    ring_we;
	logic                    res_valid_q;
	result_t                 res_q;

	assign accept = item_valid && !item_stall;
	assign item_stall = (state_q != ST_IDLE);

	// APB: register index sits in paddr[2]
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[2])
			REG_FF_COUNT: prdata = 32'(ff_cnt_q);
			REG_FB_COUNT: prdata = 32'(fb_cnt_q);
			default:      prdata = '0;
		endcase
	end

	// counts above the table size act as the table size
	assign nff = (int'(ff_cnt_q) > MAX_TAPS) ? CNT_W'(MAX_TAPS) : CNT_W'(ff_cnt_q);
	assign nfb = (int'(fb_cnt_q) > MAX_TAPS) ? CNT_W'(MAX_TAPS) : CNT_W'(fb_cnt_q);
	assign lim = fb_q ? nfb : nff;
	assign issue = (state_q == ST_RUN) && (idx_q < lim);

	// tap table: {fb, index} -> {delay, coef}
	assign tap_we = accept && (int'(item.tap_index) < MAX_TAPS) &&
		((item.kind == KIND_LOAD_FF) || (item.kind == KIND_LOAD_FB));
	assign tap_waddr = {(item.kind == KIND_LOAD_FB), TAP_AW'(item.tap_index)};
	assign tap_raddr = {fb_q, idx_q[TAP_AW-1:0]};

	always_ff @(posedge clk) begin
		if (tap_we) begin
			tap_mem[tap_waddr] <= {item.tap_delay, item.tap_coef};
		end
		tap_rd_s1 <= tap_mem[tap_raddr];
	end

	// ring address of this tap, wraps modulo the ring depth
	assign delay_s1   = tap_rd_s1[TAP_W-1:COEF_W];
	assign ring_raddr = wp_q - RING_AW'(delay_s1);

	assign ring_we = (state_q == ST_WRITE) && (!res_valid_q || !result_stall);

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[wp_q] <= {sample_q, r_q};
		end
		ring_rd_s2 <= ring_mem[ring_raddr];
	end

	always_ff @(posedge clk) begin
		if (accept && (item.kind == KIND_SAMPLE)) begin
			sample_q <= item.sample_in;
		end
	end

	sef_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (accept),
		.op        (op_s2),
		.ring_word (ring_rd_s2),
		.wpos      (wp_q),
		.sample    (sample_q),
		.wrapped   (wrapped_q),
		.busy      (mac_busy),
		.acc       (acc)
	);

	// round half up, drop fraction bits, clip to Q1.23
	assign acc_rnd = acc + ROUND_HALF;
	assign acc_sh  = acc_rnd >>> FRAC_DROP;

	always_ff @(posedge clk) begin
		if (state_q == ST_ROUND) begin
			if (acc_sh > R_MAX) begin
				r_q   <= SAMPLE_W'(SAMPLE_MAX);
				sat_q <= 1'b1;
			end else if (acc_sh < R_MIN) begin
				r_q   <= SAMPLE_W'(SAMPLE_MIN);
				sat_q <= 1'b1;
			end else begin
				r_q   <= acc_sh[SAMPLE_W-1:0];
				sat_q <= 1'b0;
			end
		end
		if (ring_we) begin
			res_q.filtered_out <= r_q;
			res_q.saturated    <= sat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ff_cnt_q     <= '0;
			fb_cnt_q     <= '0;
			wp_q         <= '0;
			wrapped_q    <= 1'b0;
			idx_q        <= '0;
			fb_q         <= 1'b0;
			v_s1         <= 1'b0;
			fb_s1        <= 1'b0;
			op_s2        <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (paddr[2] == REG_FF_COUNT) begin
					ff_cnt_q <= pwdata[CFG_W-1:0];
				end else begin
					fb_cnt_q <= pwdata[CFG_W-1:0];
				end
			end

			v_s1        <= issue;
			fb_s1       <= fb_q;
			op_s2.valid <= v_s1;
			op_s2.fb    <= fb_s1;
			op_s2.coef  <= tap_rd_s1[COEF_W-1:0];
			op_s2.addr  <= ring_raddr;

			// a new result may replace the one leaving at the same edge
			if (ring_we) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept && (item.kind == KIND_SAMPLE)) begin
						state_q <= ST_RUN;
						idx_q   <= '0;
						fb_q    <= 1'b0;
					end
				end
				ST_RUN: begin
					if (issue) begin
						idx_q <= idx_q + 1'b1;
					end else if (!fb_q) begin
						fb_q  <= 1'b1;
						idx_q <= '0;
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !op_s2.valid && !mac_busy) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (ring_we) begin
						wp_q        <= wp_q + 1'b1;
						if (wp_q == RING_AW'(RING_DEPTH - 1)) begin
							wrapped_q <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

`ifndef SYNTHESIS
	a_result_from_write: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_WRITE))
		else $error("result raised outside write-back");

	a_ring_write_ends_beat: assert property (@(posedge clk) disable iff (!arst_n)
		ring_we |=> (state_q == ST_IDLE) && result_valid)
		else $error("ring write did not complete the beat");

	a_round_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (!v_s1 && !op_s2.valid && !mac_busy))
		else $error("rounding with taps still in flight");

	a_tap_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		tap_we |-> (state_q == ST_IDLE) && !v_s1 && !mac_busy)
		else $error("tap table written during a sample");

	a_issue_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (idx_q < CNT_W'(MAX_TAPS)))
		else $error("tap index beyond table");
`endif

endmodule

// ----- tb/sv/sparse_echo_filter_checker.sv -----
`timescale 1ns / 1ps
module sparse_echo_filter_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_stall,
	input  sef_pkg::item_t   item,
	input  logic             result_valid,
	input  logic             result_stall,
	input  sef_pkg::result_t result,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	input  logic             pready,
	output int               mismatches,
	output int               outstanding
);
	import sef_pkg::*;

	bit signed [SAMPLE_W-1:0] input_ring  [RING_DEPTH];
	bit signed [SAMPLE_W-1:0] output_ring [RING_DEPTH];
	bit        [DELAY_W-1:0]  ff_delay    [MAX_TAPS];
	bit signed [COEF_W-1:0]   ff_coef     [MAX_TAPS];
	bit        [DELAY_W-1:0]  fb_delay    [MAX_TAPS];
	bit signed [COEF_W-1:0]   fb_coef     [MAX_TAPS];
	bit        [RING_AW-1:0]  wr_pos;
	bit        [CFG_W-1:0]    ff_count;
	bit        [CFG_W-1:0]    fb_count;

	result_t expected_outputs [$];
	int      results_seen;

	initial begin
		mismatches   = 0;
		outstanding  = 0;
		results_seen = 0;
	end

	task automatic report_mismatch(string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	// one sample through both rings: exact sum, round half up, clip to Q1.23
	function automatic result_t filter_sample(logic signed [SAMPLE_W-1:0] s);
		longint             acc;
		longint             rounded;
		int                 nff;
		int                 nfb;
		bit [RING_AW-1:0]   addr;
		result_t            res;
		acc = 0;
		input_ring[wr_pos] = s;
		nff = (ff_count > MAX_TAPS) ? MAX_TAPS : ff_count;
		nfb = (fb_count > MAX_TAPS) ? MAX_TAPS : fb_count;
		for (int j = 0; j < nff; j++) begin
			addr = wr_pos - ff_delay[j];
			acc += longint'(ff_coef[j]) * longint'(input_ring[addr]);
		end
		// delay 0 reads the old slot, before this sample's write-back
		for (int j = 0; j < nfb; j++) begin
			addr = wr_pos - fb_delay[j];
			acc += longint'(fb_coef[j]) * longint'(output_ring[addr]);
		end
		rounded = (acc + (longint'(1) <<< (FRAC_DROP - 1))) >>> FRAC_DROP;
		res.saturated = 1'b0;
		if (rounded > SAMPLE_MAX) begin
			rounded = SAMPLE_MAX;
			res.saturated = 1'b1;
		end else if (rounded < SAMPLE_MIN) begin
			rounded = SAMPLE_MIN;
			res.saturated = 1'b1;
		end
		res.filtered_out = SAMPLE_W'(rounded);
		output_ring[wr_pos] = res.filtered_out;
		wr_pos++;
		return res;
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			// results first: a result never belongs to a beat taken at the same edge
			if (result_valid && !result_stall) begin
				results_seen++;
				if (expected_outputs.size() == 0) begin
					report_mismatch($sformatf("result %0d (%0d/%0b) with none expected",
						results_seen, result.filtered_out, result.saturated));
				end else begin
					want = expected_outputs.pop_front();
					if (result.filtered_out !== want.filtered_out ||
					    result.saturated !== want.saturated)
						report_mismatch($sformatf("result %0d: got %0d/%0b, want %0d/%0b",
							results_seen, result.filtered_out, result.saturated,
							want.filtered_out, want.saturated));
				end
			end
			if (item_valid && !item_stall) begin
				case (item.kind)
					KIND_SAMPLE: begin
						expected_outputs.push_back(filter_sample(item.sample_in));
					end
					KIND_LOAD_FF: begin
						ff_delay[item.tap_index] = item.tap_delay;
						ff_coef[item.tap_index]  = item.tap_coef;
					end
					KIND_LOAD_FB: begin
						fb_delay[item.tap_index] = item.tap_delay;
						fb_coef[item.tap_index]  = item.tap_coef;
					end
					default: ;
				endcase
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_FF_COUNT)
					ff_count = pwdata[CFG_W-1:0];
				else
					fb_count = pwdata[CFG_W-1:0];
			end
			outstanding <= expected_outputs.size();
		end
	end

endmodule

// ----- tb/sv/sparse_echo_filter_test.sv -----
`timescale 1ns / 1ps
module sparse_echo_filter_test;
	import sef_pkg::*;

	// hard limit on the run, well above the slowest correct run
	localparam int CYCLE_LIMIT  = 1000000;
	// settle time, longer than the longest sample beat
	localparam int DRAIN_CYCLES = 2 * MAX_TAPS + 64;
	localparam int PHASES       = 10;
	localparam int PHASE_BEATS  = 35;

	typedef enum int {STALL_NONE, STALL_HALF, STALL_LIGHT, STALL_HEAVY} stall_mode_e;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        item_valid   = 1'b0;
	logic        item_stall;
	item_t       item         = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	result_t     result;
	logic        psel         = 1'b0;
	logic        penable      = 1'b0;
	logic        pwrite       = 1'b0;
	logic [2:0]  paddr        = '0;
	logic [31:0] pwdata       = '0;
	logic [31:0] prdata;
	logic        pready;

	int          mismatches;
	int          outstanding;
	int          burst_left   = 6;
	int          cycles       = 0;
	stall_mode_e stall_mode   = STALL_NONE;
	int          stall_run    = 40;

	// tap count plan per phase; the last two are drawn at random
	int ff_plan [PHASES] = '{64, 0, 127, 1, 3, 64, 0, 100, 0, 0};
	int fb_plan [PHASES] = '{64, 1, 0, 127, 2, 0, 64, 65, 0, 0};

	sparse_echo_filter DUT (.*);

	sparse_echo_filter_checker echo_check (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// hard stop
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL sparse_echo_filter");
			$finish;
		end
	end

	// receiver: stall pattern switches mode after a random run
	always @(negedge clk) begin
		if (stall_run == 0) begin
			stall_mode <= stall_mode_e'($urandom_range(0, 3));
			stall_run  <= $urandom_range(8, 120);
		end else begin
			stall_run <= stall_run - 1;
		end
		case (stall_mode)
			STALL_NONE:  result_stall <= 1'b0;
			STALL_HALF:  result_stall <= ($urandom_range(0, 1) == 1);
			STALL_LIGHT: result_stall <= ($urandom_range(0, 7) == 0);
			default:     result_stall <= ($urandom_range(0, 4) != 0);
		endcase
	end

	// drop valid for a gap set by n
	task automatic hold_off(int n);
		@(negedge clk);
		item_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// one beat on the item channel; bursts end in a random gap
	task automatic send_beat(item_t beat);
		@(negedge clk);
		item_valid <= 1'b1;
		item       <= beat;
		do @(posedge clk); while (item_stall);
		burst_left--;
		if (burst_left <= 0) begin
			// now and then a long stretch with no gaps
			burst_left = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 20);
			hold_off($urandom_range(1, 12));
		end
	endtask

	// everything answered, then let any trailing load beat settle
	task automatic wait_idle();
		hold_off(1);
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// APB write: setup then access; upper data bits are junk the block must ignore
	task automatic write_reg(logic idx, int unsigned value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= ($urandom() & ~32'h7F) | (value & 32'h7F);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// every field random, so ignored fields toggle too
	function automatic item_t noise_item();
		item_t it;
		it.kind      = 2'($urandom_range(0, 3));
		it.sample_in = SAMPLE_W'($urandom());
		it.tap_index = IDX_W'($urandom());
		it.tap_delay = DELAY_W'($urandom());
		it.tap_coef  = COEF_W'($urandom());
		return it;
	endfunction

	function automatic item_t sample_beat(int s);
		item_t it;
		it           = noise_item();
		it.kind      = KIND_SAMPLE;
		it.sample_in = SAMPLE_W'(s);
		return it;
	endfunction

	function automatic item_t tap_beat(logic [1:0] kind, int idx, int delay, int coef);
		item_t it;
		it           = noise_item();
		it.kind      = kind;
		it.tap_index = IDX_W'(idx);
		it.tap_delay = DELAY_W'(delay);
		it.tap_coef  = COEF_W'(coef);
		return it;
	endfunction

	function automatic int rand_sample();
		case ($urandom_range(0, 7))
			0:       return ($urandom_range(0, 1) == 1) ? SAMPLE_MAX : SAMPLE_MIN;
			1, 2:    return int'($urandom_range(0, 8191)) - 4096;
			default: return int'($urandom());
		endcase
	endfunction

	// mostly gains that keep the sum in range, some that clip
	function automatic int rand_coef();
		case ($urandom_range(0, 5))
			0:       return ($urandom_range(0, 1) == 1) ? SAMPLE_MAX : SAMPLE_MIN;
			1:       return ($urandom_range(0, 1) == 1) ? (1 << 20) : -(1 << 20);
			2, 3:    return int'($urandom_range(0, 16383)) - 8192;
			default: return int'($urandom());
		endcase
	endfunction

	// short delays hit written ring slots; zero hits the current slot, the top of the range wraps
	function automatic int rand_delay();
		case ($urandom_range(0, 7))
			0:          return ($urandom_range(0, 1) == 1) ? $urandom_range(0, 1)
			                                               : $urandom_range(65534, 65535);
			1, 2, 3:    return $urandom_range(0, 15);
			4:          return $urandom_range(0, 300);
			default:    return $urandom_range(0, 65535);
		endcase
	endfunction

	function automatic item_t rand_item();
		int     pick;
		item_t  it;
		pick = $urandom_range(0, 99);
		if (pick < 72)
			it = sample_beat(rand_sample());
		else if (pick < 86)
			it = tap_beat(KIND_LOAD_FF, $urandom_range(0, MAX_TAPS - 1), rand_delay(), rand_coef());
		else if (pick < 98)
			it = tap_beat(KIND_LOAD_FB, $urandom_range(0, MAX_TAPS - 1), rand_delay(), rand_coef());
		else begin
			it      = noise_item();
			it.kind = 2'd3;
		end
		return it;
	endfunction

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// fill both tap tables so any count reads written entries only
		for (int i = 0; i < MAX_TAPS; i++) begin
			send_beat(tap_beat(KIND_LOAD_FF, i, rand_delay(), rand_coef()));
			send_beat(tap_beat(KIND_LOAD_FB, i, rand_delay(), rand_coef()));
		end

		// --- directed ---
		// unused kind: no result
		begin
			item_t junk;
			junk      = noise_item();
			junk.kind = 2'd3;
			send_beat(junk);
		end
		// counts still at reset: no taps, output zero
		send_beat(sample_beat(SAMPLE_MAX));
		send_beat(sample_beat(SAMPLE_MIN));
		// last table entries at the extremes, used once counts reach 64
		send_beat(tap_beat(KIND_LOAD_FF, MAX_TAPS - 1, 65535, SAMPLE_MIN));
		send_beat(tap_beat(KIND_LOAD_FB, MAX_TAPS - 1, 65535, SAMPLE_MAX));

		wait_idle();
		write_reg(REG_FF_COUNT, 1);
		write_reg(REG_FB_COUNT, 1);

		// unity feedforward with zero delay, feedback off: output follows input
		send_beat(tap_beat(KIND_LOAD_FF, 0, 0, 1 << 20));
		send_beat(tap_beat(KIND_LOAD_FB, 0, 1, 0));
		send_beat(sample_beat(SAMPLE_MAX));
		send_beat(sample_beat(SAMPLE_MIN));
		send_beat(sample_beat(-1));
		send_beat(sample_beat(0));
		// one-lsb gain: exact halves round up, just below half drops
		send_beat(tap_beat(KIND_LOAD_FF, 0, 0, 1));
		send_beat(sample_beat(1 << 19));
		send_beat(sample_beat(-(1 << 19)));
		send_beat(sample_beat((1 << 19) - 1));
		// full-scale gain clips both ways
		send_beat(tap_beat(KIND_LOAD_FF, 0, 0, SAMPLE_MAX));
		send_beat(sample_beat(SAMPLE_MAX));
		send_beat(sample_beat(SAMPLE_MIN));
		// longest delay wraps back to a slot never written
		send_beat(tap_beat(KIND_LOAD_FF, 0, 65535, 1 << 20));
		// feedback delay zero reads the slot before its write-back
		send_beat(tap_beat(KIND_LOAD_FB, 0, 0, SAMPLE_MIN));
		send_beat(sample_beat(12345));
		// unity echo on the last output: builds up until it clips
		send_beat(tap_beat(KIND_LOAD_FF, 0, 0, 1 << 20));
		send_beat(tap_beat(KIND_LOAD_FB, 0, 1, 1 << 20));
		send_beat(sample_beat(SAMPLE_MAX));
		send_beat(sample_beat(SAMPLE_MAX));

		// --- random phases over the count plan ---
		for (int p = 0; p < PHASES; p++) begin
			if (p >= PHASES - 2) begin
				ff_plan[p] = $urandom_range(0, 127);
				fb_plan[p] = $urandom_range(0, 127);
			end
			wait_idle();
			write_reg(REG_FF_COUNT, ff_plan[p]);
			write_reg(REG_FB_COUNT, fb_plan[p]);
			repeat (PHASE_BEATS) send_beat(rand_item());
		end

		wait_idle();
		if (mismatches == 0)
			$display("PASS sparse_echo_filter");
		else
			$display("FAIL sparse_echo_filter");
		$finish;
	end

endmodule
